// ----- hw/rtl/psf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, sizes and classification codes for the prime stream filter.
// No dependencies; every other file of the block imports this package.
package psf_pkg;

  localparam int VALUE_BITS    = 16;
  localparam int LIST_CAPACITY = 128;

  localparam int DIV_BITS   = (VALUE_BITS + 1) / 2;
  localparam int SQ_BITS    = 2 * DIV_BITS + 2;
  localparam int COUNT_BITS = $clog2(LIST_CAPACITY + 1);

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NOT_PRIME = 2'd0;
  localparam kind_t KIND_PRIME     = 2'd1;
  localparam kind_t KIND_TEST      = 2'd2;

  typedef struct packed {
    logic [15:0] value;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [15:0] prime_value;
    logic [6:0]  position;
  } out_item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] n;
    logic                  last_item;
    kind_t                 kind;
  } entry_t;

endpackage

// ----- hw/rtl/prime_stream_filter.sv -----
`timescale 1ns / 1ps
// Prime stream filter top level: front end, item queue and trial-division back end.
// Depends on psf_pkg, psf_front, psf_queue and psf_back.
//
// Each input item carries a 16-bit value and a last-of-list mark. Values below 4
// and all other even values are settled on entry; every other value is tried
// against odd divisors d = 3, 5, ... while d*d <= value, one divisor entering a
// 16-stage remainder pipeline per cycle. The back end works on one item at a
// time; a two-entry queue lets the input side keep accepting items meanwhile,
// until it is full. A prime leaves with its position in the current list; primes
// beyond the list capacity of 128 are dropped, and the count clears after the
// item marked last.
module prime_stream_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  psf_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output psf_pkg::out_item_t result
);
  import psf_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   avail;
  entry_t pop_entry;

  psf_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  psf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .avail      (avail),
    .pop_entry  (pop_entry)
  );

  psf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (avail),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- hw/rtl/psf_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input items, masks the value and sorts out the trivial cases.
// Depends on psf_pkg; feeds psf_queue.
module psf_front (
  input  logic              item_valid,
  output logic              item_stall,
  input  psf_pkg::in_item_t item,
  output logic              push,
  output psf_pkg::entry_t   push_entry,
  input  logic              full
);
  import psf_pkg::*;

  logic [VALUE_BITS-1:0] n;
  logic                  below_two;
  logic                  tiny_prime;
  logic                  even;

  assign n          = VALUE_BITS'(item.value);
  assign below_two  = (n == VALUE_BITS'(0)) || (n == VALUE_BITS'(1));
  assign tiny_prime = (n == VALUE_BITS'(2)) || (n == VALUE_BITS'(3));
  assign even       = !n[0];

  always_comb begin
    push_entry.n         = n;
    push_entry.last_item = item.last_item;
    priority if (below_two) begin
      push_entry.kind = KIND_NOT_PRIME;
    end else if (tiny_prime) begin
      push_entry.kind = KIND_PRIME;
    end else if (even) begin
      push_entry.kind = KIND_NOT_PRIME;
    end else begin
      push_entry.kind = KIND_TEST;
    end
  end

  assign item_stall = full;
  assign push       = item_valid && !full;

endmodule

// ----- hw/rtl/psf_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of classified items between the front end and the test engine.
// Depends on psf_pkg.
module psf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psf_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output psf_pkg::entry_t pop_entry
);
  import psf_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign avail     = (count != 2'd0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/psf_back.sv -----
`timescale 1ns / 1ps
// Back end: trial division over odd divisors through a pipelined remainder unit,
// list counting and the output register. Depends on psf_pkg; fed by psf_queue.
module psf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  psf_pkg::entry_t    pop_entry,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output psf_pkg::out_item_t result
);
  import psf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TEST = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(LIST_CAPACITY);

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] n;
  logic                  last_item;
  kind_t                 kind;
  logic [DIV_BITS:0]     d;
  logic [SQ_BITS-1:0]    sq;
  logic                  hit;
  logic [COUNT_BITS-1:0] kept_count;

  logic [VALUE_BITS-1:0] pv;
  logic [VALUE_BITS-1:0] pv_next;
  logic [DIV_BITS-1:0]   pd      [VALUE_BITS];
  logic [DIV_BITS-1:0]   pd_next [VALUE_BITS];
  logic [DIV_BITS-1:0]   pr      [VALUE_BITS];
  logic [DIV_BITS-1:0]   pr_next [VALUE_BITS];

  logic issue;
  logic sq_over;
  logic verdict;
  logic keep;
  logic out_free;
  logic finish;

  assign sq_over  = sq > SQ_BITS'(n);
  assign issue    = (state == S_TEST) && !hit && !sq_over;
  assign pop      = (state == S_IDLE) && avail;
  assign verdict  = (kind == KIND_PRIME) || ((kind == KIND_TEST) && !hit);
  assign keep     = verdict && (kept_count < CAP_COUNT);
  assign out_free = !result_valid || !result_stall;
  assign finish   = (state == S_DONE) && (!keep || out_free);

  always_comb begin
    logic [DIV_BITS-1:0] r_in;
    logic [DIV_BITS-1:0] d_in;
    logic [DIV_BITS:0]   t;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (i == 0) begin
        pv_next[i] = issue;
        d_in       = d[DIV_BITS-1:0];
        r_in       = '0;
      end else begin
        pv_next[i] = pv[i-1];
        d_in       = pd[i-1];
        r_in       = pr[i-1];
      end
      t          = {r_in, n[VALUE_BITS-1-i]};
      pd_next[i] = d_in;
      if (t >= {1'b0, d_in}) begin
        pr_next[i] = DIV_BITS'(t - {1'b0, d_in});
      end else begin
        pr_next[i] = DIV_BITS'(t);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      pd[i] <= pd_next[i];
      pr[i] <= pr_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      n         <= pop_entry.n;
      last_item <= pop_entry.last_item;
      kind      <= pop_entry.kind;
    end
    if ((state == S_DONE) && keep && out_free) begin
      result.prime_value <= 16'(n);
      result.position    <= 7'(kept_count);
    end
    if (pop) begin
      d  <= (DIV_BITS + 1)'(3);
      sq <= SQ_BITS'(9);
    end else if (issue) begin
      d  <= d + (DIV_BITS + 1)'(2);
      sq <= sq + (SQ_BITS'(d) << 2) + SQ_BITS'(4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pv           <= '0;
      hit          <= 1'b0;
      kept_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      pv <= pv_next;

      if (pop) begin
        hit <= 1'b0;
      end else if (pv[VALUE_BITS-1] && (pr[VALUE_BITS-1] == '0)) begin
        hit <= 1'b1;
      end

      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if ((state == S_DONE) && keep && out_free) begin
        result_valid <= 1'b1;
      end

      if (finish) begin
        if (last_item) begin
          kept_count <= '0;
        end else if (keep) begin
          kept_count <= kept_count + COUNT_BITS'(1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (pop) begin
            state <= (pop_entry.kind == KIND_TEST) ? S_TEST : S_DONE;
          end
        end
        S_TEST: begin
          if ((hit || sq_over) && (pv == '0)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for prime_stream_filter: directed lists, then random streams.
// Depends on psf_pkg and the prime_stream_filter RTL.
module tb_top;
  import psf_pkg::*;

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  in_item_t  item;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  out_item_t pending_primes[$];
  logic [7:0] kept_count;
  int mismatch_count = 0;
  int send_idle_pct;
  int recv_stall_pct;

  prime_stream_filter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #1 clk = ~clk;

  function automatic bit value_is_prime(input int n);
    int d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [15:0] next_prime(input int n);
    int k;
    k = (n < 2) ? 2 : n;
    while (k <= 65535 && !value_is_prime(k)) k++;
    if (k > 65535) return 16'd65521;
    return k[15:0];
  endfunction

  function automatic void predict_item(input in_item_t it);
    out_item_t r;
    if (value_is_prime(int'(it.value)) && kept_count < LIST_CAPACITY) begin
      r.prime_value = it.value;
      r.position = kept_count[6:0];
      pending_primes.push_back(r);
      kept_count++;
    end
    if (it.last_item) kept_count = '0;
  endfunction

  task automatic send_value(input logic [15:0] v, input logic last);
    in_item_t it;
    it.value = v;
    it.last_item = last;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_item(it);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_primes.size() == 0) begin
        $error("unexpected result: prime_value %0d position %0d",
               result.prime_value, result.position);
        mismatch_count++;
      end else begin
        want = pending_primes.pop_front();
        if (result.prime_value !== want.prime_value) begin
          $error("prime_value: expected %0d, got %0d", want.prime_value, result.prime_value);
          mismatch_count++;
        end
        if (result.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, result.position);
          mismatch_count++;
        end
      end
    end
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic test_low_values();
    send_value(16'd0, 1'b0);
    send_value(16'd1, 1'b0);
    send_value(16'd2, 1'b0);
    send_value(16'd3, 1'b0);
    send_value(16'd4, 1'b0);
    send_value(16'd1, 1'b1);
  endtask

  task automatic test_extremes();
    send_value(16'd65535, 1'b0);
    send_value(16'd65521, 1'b0);
    send_value(16'd65534, 1'b0);
    send_value(16'd32768, 1'b0);
    send_value(16'd63001, 1'b0);
    send_value(16'd65025, 1'b0);
    send_value(16'd9, 1'b0);
    send_value(16'd65519, 1'b1);
  endtask

  task automatic test_list_end();
    send_value(16'd3, 1'b0);
    send_value(16'd5, 1'b0);
    send_value(16'd4, 1'b1);
    send_value(16'd7, 1'b0);
    send_value(16'd11, 1'b1);
    send_value(16'd13, 1'b1);
    send_value(16'd0, 1'b1);
  endtask

  task automatic test_capacity();
    int p;
    int i;
    p = 2;
    for (i = 0; i < 134; i++) begin
      send_value(next_prime(p), 1'b0);
      p = int'(next_prime(p)) + 1;
    end
    send_value(next_prime(p), 1'b1);
    send_value(16'd2, 1'b1);
  endtask

  task automatic test_random_stream(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int left;
    bit crowded;
    logic [15:0] v;
    logic last;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    left = 0;
    crowded = 1'b0;
    for (sent = 0; sent < n_items; sent++) begin
      if (left == 0) begin
        crowded = ($urandom_range(11) == 0);
        left = crowded ? $urandom_range(129, 150) : $urandom_range(1, 16);
      end
      if (crowded && $urandom_range(9) < 8) begin
        v = next_prime($urandom_range(2, 2000));
      end else begin
        case ($urandom_range(9))
          0, 1: v = next_prime($urandom_range(65535));
          2, 3: v = next_prime($urandom_range(2, 1000));
          4, 5: v = 16'($urandom_range(65535));
          6: v = 16'($urandom_range(3));
          7: v = {15'($urandom_range(32767)), 1'b0};
          8: begin
            case ($urandom_range(3))
              0: v = 16'd65535;
              1: v = 16'd65521;
              2: v = 16'd65534;
              default: v = 16'd32768;
            endcase
          end
          default: begin
            v = next_prime($urandom_range(2, 251));
            v = v * v;
          end
        endcase
      end
      left--;
      last = (left == 0) || ($urandom_range(19) == 0);
      if (last) left = 0;
      send_value(v, last);
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    kept_count = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_low_values();
    test_extremes();
    test_list_end();
    drain_results();
    send_idle_pct = 30;
    recv_stall_pct = 30;
    test_capacity();
    drain_results();
    test_random_stream(440, 0, 0);
    test_random_stream(440, 60, 0);
    drain_results();
    test_random_stream(440, 0, 60);
    test_random_stream(440, 7, 7);
    drain_results();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
